// ----- design/dq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue package
// Field widths, operation and status codes shared by the queue files.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Widths of the payload fields.
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned COUNT_W  = 5;

    // Word returned when nothing is removed.
    localparam logic signed [VALUE_W-1:0] NO_WORD = '1;

    // Operation requested by one command.
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    // Outcome of one command.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Bookkeeping carried with each command through the memory read stage.
    typedef struct packed {
        logic                 pop_hit;
        t_status              status;
        logic [COUNT_W-1:0]   count;
    } t_stage;

endpackage
`default_nettype wire

// ----- design/dq_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue channels
// Valid/ready channels for commands into the queue and results out of it.
// ----------------------------------------------------------------------------

// Command channel: one operation and an optional word to push.
interface dq_cmd_if;
    import dq_pkg::*;

    logic                      valid;
    logic                      ready;
    t_mode                     mode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// Result channel: removed word, status and entries held afterwards.
interface dq_rsp_if;
    import dq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] popped_value;
    t_status                   status;
    logic [COUNT_W-1:0]        entry_count;

    modport source (output valid, output popped_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input entry_count, output ready);
endinterface
`default_nettype wire

// ----- design/double_ended_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue
// Circular store of signed words with a head index and an entry count,
// supporting push and pop at both ends.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                               Transfer rule
//  i_cmd    in         mode, value                           valid & ready
//  o_rsp    out        popped_value, status, entry_count     valid & ready
//
//  One command per cycle is accepted while the result is not stalled; its result
//  passes through the registered RAM read and then the output register.
//  Head index and count update at acceptance, so back-to-back commands see
//  the new state; the RAM write lands before any later read of that entry.
//  A stalled result holds the read stage, which then stops accepting commands.
//  Reset clears the head index, the count and the valid flags; RAM contents
//  stay undefined and are never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dq_cmd_if.sink    i_cmd,
    dq_rsp_if.source  o_rsp
);
    import dq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam int unsigned EW = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Queue state.
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    // Read stage and output register.
    logic          r_s1_valid;
    t_stage        r_s1, n_s1;
    logic          r_out_valid;

    // Memory port signals.
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [VALUE_W-1:0]  rd_data;

    logic          accept, s1_advance;
    logic [AW-1:0] head_dec, head_inc, back_idx, tail_idx;
    logic [SW-1:0] tail_sum, back_sum;
    logic [EW-1:0] count_ext;

    // Handshake: the read stage moves on when the output register is free.
    assign s1_advance  = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = !r_s1_valid || s1_advance;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Wrapped index arithmetic around the circular store.
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign back_sum = tail_sum - SW'(1);
    assign tail_idx = AW'((tail_sum >= DEPTH_S) ? tail_sum - DEPTH_S : tail_sum);
    assign back_idx = AW'((back_sum >= DEPTH_S) ? back_sum - DEPTH_S : back_sum);

    // Decode the command into state updates and one memory access.
    always_comb begin
        n_head        = r_head;
        n_count       = r_count;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        wr_addr       = tail_idx;
        rd_addr       = r_head;
        n_s1.pop_hit  = 1'b0;
        n_s1.status   = STATUS_OK;
        case (i_cmd.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (r_count == FULL_CNT) begin
                    n_s1.status = STATUS_FULL;
                end else begin
                    wr_en   = accept;
                    n_count = r_count + CW'(1);
                    if (i_cmd.mode == MODE_PUSH_FRONT) begin
                        wr_addr = head_dec;
                        n_head  = head_dec;
                    end
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                if (r_count == '0) begin
                    n_s1.status = STATUS_EMPTY;
                end else begin
                    rd_en        = accept;
                    n_s1.pop_hit = 1'b1;
                    n_count      = r_count - CW'(1);
                    if (i_cmd.mode == MODE_POP_FRONT) begin
                        n_head = head_inc;
                    end else begin
                        rd_addr = back_idx;
                    end
                end
            end
            default: begin
                n_s1.status = STATUS_OK;
            end
        endcase
        count_ext  = EW'(n_count);
        n_s1.count = count_ext[COUNT_W-1:0];
    end

    // Entry store.
    dq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Queue state and pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cmd.ready) begin
                r_s1_valid <= accept;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Stage payload and output register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_advance && r_s1_valid) begin
            o_rsp.popped_value <= r_s1.pop_hit ? $signed(rd_data) : NO_WORD;
            o_rsp.status       <= r_s1.status;
            o_rsp.entry_count  <= r_s1.count;
        end
    end

    assign o_rsp.valid = r_out_valid;

endmodule
`default_nettype wire

// ----- design/dq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds while no read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- tb/double_ended_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push and pop commands at both ends of the queue through the command
// channel and checks every result against a shadow copy of the circular
// store. The run covers empty and full cases, wraparound of the head index,
// random gaps on both channels and one long stall of the result channel.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import dq_pkg::*;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned IDX_W      = $clog2(DEPTH);
    localparam int unsigned LONG_HOLD  = 64;
    localparam int unsigned RAND_OPS   = 150;
    localparam int unsigned DRAIN_WAIT = 8;
    localparam int unsigned TIMEOUT_NS = 2_000_000;
    localparam int unsigned SHOW_MAX   = 10;

    // One command waiting to be sent.
    typedef struct {
        t_mode                     mode;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    // One result the queue is expected to return.
    typedef struct {
        logic signed [VALUE_W-1:0] popped_value;
        t_status                   status;
        logic [COUNT_W-1:0]        entry_count;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dq_cmd_if cmd_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow of the circular store.
    logic signed [VALUE_W-1:0] shadow_words [DEPTH];
    logic [IDX_W-1:0]          shadow_head  = '0;
    logic [COUNT_W-1:0]        shadow_held  = '0;

    t_cmd    cmd_backlog[$];
    t_result awaited_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_armed    = 1'b0;
    logic        hold_spent    = 1'b0;
    int unsigned hold_left     = 0;

    int unsigned fail_count    = 0;
    int unsigned checked_count = 0;
    int unsigned mode_seen   [4];
    int unsigned status_seen [4];
    int unsigned peak_held     = 0;

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Known input values from time zero while reset is held, then reset release.
    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.mode  = MODE_PUSH_FRONT;
        cmd_ch.value = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Apply one command to the shadow store and return the expected result.
    function automatic t_result apply_deque_op(t_mode op,
                                               logic signed [VALUE_W-1:0] word);
        t_result          res;
        logic [IDX_W-1:0] slot;
        res.popped_value = NO_WORD;
        res.status       = STATUS_OK;
        if (op == MODE_PUSH_FRONT || op == MODE_PUSH_BACK) begin
            if (shadow_held == DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                if (op == MODE_PUSH_FRONT) begin
                    shadow_head = shadow_head - 1'b1;
                    slot = shadow_head;
                end else begin
                    slot = shadow_head + shadow_held[IDX_W-1:0];
                end
                shadow_words[slot] = word;
                shadow_held = shadow_held + 1'b1;
            end
        end else begin
            if (shadow_held == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                if (op == MODE_POP_FRONT) begin
                    slot = shadow_head;
                    shadow_head = shadow_head + 1'b1;
                end else begin
                    slot = shadow_head + shadow_held[IDX_W-1:0] - 1'b1;
                end
                res.popped_value = shadow_words[slot];
                shadow_held = shadow_held - 1'b1;
            end
        end
        res.entry_count = shadow_held;
        return res;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= SHOW_MAX) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic add_cmd(t_mode op, logic signed [VALUE_W-1:0] word);
        t_cmd c;
        c.mode  = op;
        c.value = word;
        cmd_backlog.push_back(c);
    endtask

    // Mostly random words, with the corner values now and then.
    function automatic logic signed [VALUE_W-1:0] pick_word();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // Random commands in bursts that lean toward pushes, pops or neither,
    // so the queue swings between empty and full and the head wraps.
    task automatic add_random_cmds(int unsigned n);
        int unsigned made;
        int unsigned burst_left;
        int unsigned push_pct;
        logic        at_back;
        made       = 0;
        burst_left = 0;
        push_pct   = 50;
        while (made < n) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            at_back = $urandom_range(1);
            if ($urandom_range(99) < push_pct) begin
                add_cmd(at_back ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_word());
            end else begin
                add_cmd(at_back ? MODE_POP_BACK : MODE_POP_FRONT, pick_word());
            end
            burst_left--;
            made++;
        end
    endtask

    // Wait until every queued command has been transferred.
    task automatic wait_backlog_sent();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || cmd_ch.valid);
    endtask

    // Command driver: predicts each transfer and offers the next command.
    always @(posedge i_clk) begin
        t_cmd nxt;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                awaited_results.push_back(apply_deque_op(cmd_ch.mode, cmd_ch.value));
                mode_seen[cmd_ch.mode]++;
            end
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmd_backlog.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.mode  <= nxt.mode;
                    cmd_ch.value <= nxt.value;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off counter: starts once when armed, then counts down.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_armed && !hold_spent) begin
            hold_spent <= 1'b1;
            hold_left  <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result ready: random stalls, and held low during the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if ((hold_armed && !hold_spent) || hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor: compares each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
                note_failure($sformatf("unexpected result: value=%0d status=%0d count=%0d",
                                       rsp_ch.popped_value, rsp_ch.status,
                                       rsp_ch.entry_count));
            end else begin
                want = awaited_results.pop_front();
                checked_count++;
                status_seen[want.status]++;
                if (want.entry_count > peak_held) begin
                    peak_held = want.entry_count;
                end
                if (rsp_ch.popped_value !== want.popped_value ||
                    rsp_ch.status !== want.status ||
                    rsp_ch.entry_count !== want.entry_count) begin
                    note_failure($sformatf(
                        {"result %0d: expected value=%0d status=%0d count=%0d,",
                         " got value=%0d status=%0d count=%0d"},
                        checked_count, want.popped_value, want.status, want.entry_count,
                        rsp_ch.popped_value, rsp_ch.status, rsp_ch.entry_count));
                end
            end
        end
    end

    // Stimulus sequence: directed commands, then three random phases.
    initial begin
        while (!i_rst_n) @(negedge i_clk);
        @(negedge i_clk);
        send_idle_pct = 26;
        recv_idle_pct = 83;

        // Pops of an empty queue, then the extreme words at both ends.
        add_cmd(MODE_POP_FRONT, 32'sh1234_5678);
        add_cmd(MODE_POP_BACK, '0);
        add_cmd(MODE_PUSH_FRONT, 32'sh8000_0000);
        add_cmd(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
        add_cmd(MODE_POP_BACK, '0);
        add_cmd(MODE_POP_FRONT, '0);
        add_cmd(MODE_PUSH_BACK, '0);
        add_cmd(MODE_PUSH_FRONT, '1);
        // Fill to capacity from both ends, so the head wraps below zero.
        for (int i = 0; i < DEPTH - 2; i++) begin
            add_cmd((i % 2 == 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, 32'sh5555_0000 + i);
        end
        // Pushes into a full queue are dropped, then one pop at each end.
        add_cmd(MODE_PUSH_FRONT, 32'shAAAA_AAAA);
        add_cmd(MODE_PUSH_BACK, 32'sh5555_5555);
        add_cmd(MODE_POP_FRONT, '0);
        add_cmd(MODE_POP_BACK, '0);
        add_random_cmds(RAND_OPS);
        wait_backlog_sent();

        send_idle_pct = 83;
        recv_idle_pct = 26;
        add_random_cmds(RAND_OPS);
        wait_backlog_sent();

        // No idling; the result side holds off once so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed    = 1'b1;
        add_random_cmds(RAND_OPS);
        wait_backlog_sent();

        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("Checked %0d results: %0d push-front, %0d push-back, %0d pop-front, %0d %s",
                 checked_count, mode_seen[MODE_PUSH_FRONT], mode_seen[MODE_PUSH_BACK],
                 mode_seen[MODE_POP_FRONT], mode_seen[MODE_POP_BACK], "pop-back.");
        $display("Empty pops %0d, refused pushes %0d, peak occupancy %0d, failures %0d.",
                 status_seen[STATUS_EMPTY], status_seen[STATUS_FULL], peak_held, fail_count);
        if (fail_count == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d commands unsent and %0d results outstanding.",
                 cmd_backlog.size(), awaited_results.size());
        $display("[double_ended_queue] ERROR");
        $finish;
    end

endmodule
